/* sv/dcmu_pkg.sv */
// Shared types and constants for the donor-cell momentum update block.
// No dependencies.
`timescale 1ns / 1ps

package dcmu_pkg;

  typedef enum logic [1:0] {
    KindFluid     = 2'd0,
    KindObstMinus = 2'd1,
    KindObstPlus  = 2'd2,
    KindOther     = 2'd3
  } cell_kind_e;

  typedef enum logic [1:0] {
    TgtThis  = 2'd0,
    TgtMinus = 2'd1,
    TgtNone  = 2'd2
  } write_target_e;

  typedef enum logic [2:0] {
    RegTimeStep    = 3'd0,
    RegInvRe       = 3'd1,
    RegInvDx       = 3'd2,
    RegInvDy       = 3'd3,
    RegUpwindBlend = 3'd4,
    RegGravityX    = 3'd5,
    RegGravityY    = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] vel_center;
    logic signed [31:0] vel_along_plus;
    logic signed [31:0] vel_along_minus;
    logic signed [31:0] vel_cross_plus;
    logic signed [31:0] vel_cross_minus;
    logic signed [31:0] trans_here;
    logic signed [31:0] trans_along_plus;
    logic signed [31:0] trans_cross_minus;
    logic signed [31:0] trans_cross_minus_plus;
    logic [1:0]         cell_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] momentum;
    logic [1:0]         write_target;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [30:0] time_step;
    logic [30:0] inv_reynolds;
    logic [30:0] inv_cell_width;
    logic [30:0] inv_cell_height;
    logic [16:0] upwind_blend;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
  } cfg_t;

  // Saturate a 36-bit signed value to 32 bits, flag clipping in bit 32.
  function automatic logic [32:0] sat36(input logic signed [35:0] x);
    logic [32:0] r;
    if (x > 36'sh07FFFFFFF)       r = {1'b1, 32'h7FFFFFFF};
    else if (x < -36'sh080000000) r = {1'b1, 32'h80000000};
    else                          r = {1'b0, x[31:0]};
    return r;
  endfunction

endpackage

/* sv/dcmu_fmul.sv */
// Fixed-point multiply: round half up, floor shift, saturate to 32 bits.
// Combinational, one multiplier; no dependencies.
`timescale 1ns / 1ps

module dcmu_fmul #(
  parameter int unsigned FracBits = 16
) (
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [31:0] p_o,
  output logic               clip_o
);
  logic signed [65:0] prod;
  logic signed [65:0] shr;
  logic [32:0]        s;

  always_comb begin
    prod = 66'(a_i) * 66'(b_i) + (66'sd1 <<< (FracBits - 1));
    shr  = prod >>> FracBits;
    if (shr > 66'sh07FFFFFFF)       s = {1'b1, 32'h7FFFFFFF};
    else if (shr < -66'sh080000000) s = {1'b1, 32'h80000000};
    else                            s = {1'b0, shr[31:0]};
    p_o    = s[31:0];
    clip_o = s[32];
  end
endmodule

/* sv/dcmu_core.sv */
// Seven-stage pipelined datapath of the momentum stencil.
// Depends on dcmu_pkg and dcmu_fmul.
`timescale 1ns / 1ps

module dcmu_core #(
  parameter int unsigned FracBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  dcmu_pkg::in_item_t item_i,
  input  dcmu_pkg::cfg_t     cfg_i,
  output logic              valid_o,
  output dcmu_pkg::out_item_t item_o
);
  localparam int unsigned NStg = 7;

  function automatic logic signed [32:0] x33(input logic signed [31:0] v);
    return 33'(v);
  endfunction
  function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
    return v[31] ? -x33(v) : x33(v);
  endfunction
  function automatic logic signed [31:0] half(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = x33(a) + x33(b);
    return s[32:1];
  endfunction
  function automatic logic signed [31:0] hdif(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = x33(a) - x33(b);
    return s[32:1];
  endfunction

  logic [NStg-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[NStg-1];

  // ---------------- Stage 1: halved sums/diffs, laplacians, squares, blend products
  logic signed [31:0] ia, ic, g;
  logic signed [32:0] ia2_p, ic2_p, ali_p;
  logic signed [31:0] ia2_w, ic2_w, ali_w, alc_w;
  logic [3:0]         c1_w;
  logic [32:0]        la_s, lc_s;
  assign ia = item_i.opcode ? {1'b0, cfg_i.inv_cell_height} : {1'b0, cfg_i.inv_cell_width};
  assign ic = item_i.opcode ? {1'b0, cfg_i.inv_cell_width} : {1'b0, cfg_i.inv_cell_height};
  assign g  = item_i.opcode ? cfg_i.gravity_y : cfg_i.gravity_x;
  assign ia2_p = x33(ia);
  assign ic2_p = x33(ic);
  assign ali_p = {16'd0, cfg_i.upwind_blend};
  dcmu_fmul #(.FracBits(FracBits)) u_m1a (
    .a_i(ia2_p), .b_i(ia2_p), .p_o(ia2_w), .clip_o(c1_w[0])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m1b (
    .a_i(ic2_p), .b_i(ic2_p), .p_o(ic2_w), .clip_o(c1_w[1])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m1c (
    .a_i(ali_p), .b_i(ia2_p), .p_o(ali_w), .clip_o(c1_w[2])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m1d (
    .a_i(ali_p), .b_i(ic2_p), .p_o(alc_w), .clip_o(c1_w[3])
  );
  always_comb begin
    la_s = dcmu_pkg::sat36(36'(item_i.vel_along_plus) - (36'(item_i.vel_center) <<< 1)
                           + 36'(item_i.vel_along_minus));
    lc_s = dcmu_pkg::sat36(36'(item_i.vel_cross_plus) - (36'(item_i.vel_center) <<< 1)
                           + 36'(item_i.vel_cross_minus));
  end

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c;
    logic signed [31:0] am;
    logic signed [31:0] ia, ic, g, ia2, ic2, ali, alc;
    logic signed [31:0] lap_a, lap_c;
    logic signed [31:0] hp, hm, tp, tm;
    logic signed [31:0] cxp, cxm, dap, dam, dxp, dxm;
    logic               clip;
  } s1_t;
  s1_t s1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.kind  <= item_i.cell_kind;
      s1_q.c     <= item_i.vel_center;
      s1_q.am    <= item_i.vel_along_minus;
      s1_q.ia    <= ia;
      s1_q.ic    <= ic;
      s1_q.g     <= g;
      s1_q.ia2   <= ia2_w;
      s1_q.ic2   <= ic2_w;
      s1_q.ali   <= ali_w;
      s1_q.alc   <= alc_w;
      s1_q.lap_a <= la_s[31:0];
      s1_q.lap_c <= lc_s[31:0];
      s1_q.hp    <= half(item_i.vel_center, item_i.vel_along_plus);
      s1_q.hm    <= half(item_i.vel_along_minus, item_i.vel_center);
      s1_q.tp    <= half(item_i.trans_here, item_i.trans_along_plus);
      s1_q.tm    <= half(item_i.trans_cross_minus, item_i.trans_cross_minus_plus);
      s1_q.cxp   <= half(item_i.vel_center, item_i.vel_cross_plus);
      s1_q.cxm   <= half(item_i.vel_cross_minus, item_i.vel_center);
      s1_q.dap   <= hdif(item_i.vel_center, item_i.vel_along_plus);
      s1_q.dam   <= hdif(item_i.vel_along_minus, item_i.vel_center);
      s1_q.dxp   <= hdif(item_i.vel_center, item_i.vel_cross_plus);
      s1_q.dxm   <= hdif(item_i.vel_cross_minus, item_i.vel_center);
      s1_q.clip  <= (|c1_w) | la_s[32] | lc_s[32];
    end
  end

  // ---------------- Stage 2: first-level products
  logic signed [31:0] p2 [8];
  logic [7:0]         c2;
  dcmu_fmul #(.FracBits(FracBits)) u_m2a (
    .a_i(x33(s1_q.lap_a)), .b_i(x33(s1_q.ia2)), .p_o(p2[0]), .clip_o(c2[0])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2b (
    .a_i(x33(s1_q.lap_c)), .b_i(x33(s1_q.ic2)), .p_o(p2[1]), .clip_o(c2[1])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2c (
    .a_i(x33(s1_q.hp)), .b_i(x33(s1_q.hp)), .p_o(p2[2]), .clip_o(c2[2])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2d (
    .a_i(x33(s1_q.hm)), .b_i(x33(s1_q.hm)), .p_o(p2[3]), .clip_o(c2[3])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2e (
    .a_i(abs33(s1_q.hp)), .b_i(x33(s1_q.dap)), .p_o(p2[4]), .clip_o(c2[4])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2f (
    .a_i(abs33(s1_q.hm)), .b_i(x33(s1_q.dam)), .p_o(p2[5]), .clip_o(c2[5])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2g (
    .a_i(x33(s1_q.tp)), .b_i(x33(s1_q.cxp)), .p_o(p2[6]), .clip_o(c2[6])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2h (
    .a_i(x33(s1_q.tm)), .b_i(x33(s1_q.cxm)), .p_o(p2[7]), .clip_o(c2[7])
  );
  logic signed [31:0] ep_w, em_w;
  logic [1:0]         ce_w;
  dcmu_fmul #(.FracBits(FracBits)) u_m2i (
    .a_i(abs33(s1_q.tp)), .b_i(x33(s1_q.dxp)), .p_o(ep_w), .clip_o(ce_w[0])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m2j (
    .a_i(abs33(s1_q.tm)), .b_i(x33(s1_q.dxm)), .p_o(em_w), .clip_o(ce_w[1])
  );

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c, am, ia, ic, g, ali, alc;
    logic signed [31:0] la, lc, hpp, hmm, dp, dm, cp, cm, ep, em;
    logic               clip;
  } s2_t;
  s2_t s2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q.kind <= s1_q.kind;
      s2_q.c    <= s1_q.c;
      s2_q.am   <= s1_q.am;
      s2_q.ia   <= s1_q.ia;
      s2_q.ic   <= s1_q.ic;
      s2_q.g    <= s1_q.g;
      s2_q.ali  <= s1_q.ali;
      s2_q.alc  <= s1_q.alc;
      s2_q.la   <= p2[0];
      s2_q.lc   <= p2[1];
      s2_q.hpp  <= p2[2];
      s2_q.hmm  <= p2[3];
      s2_q.dp   <= p2[4];
      s2_q.dm   <= p2[5];
      s2_q.cp   <= p2[6];
      s2_q.cm   <= p2[7];
      s2_q.ep   <= ep_w;
      s2_q.em   <= em_w;
      s2_q.clip <= s1_q.clip | (|c2) | (|ce_w);
    end
  end

  // ---------------- Stage 3: saturated sum and differences
  logic [32:0] d3 [5];
  always_comb begin
    d3[0] = dcmu_pkg::sat36(36'(s2_q.la) + 36'(s2_q.lc));
    d3[1] = dcmu_pkg::sat36(36'(s2_q.hpp) - 36'(s2_q.hmm));
    d3[2] = dcmu_pkg::sat36(36'(s2_q.dp) - 36'(s2_q.dm));
    d3[3] = dcmu_pkg::sat36(36'(s2_q.cp) - 36'(s2_q.cm));
    d3[4] = dcmu_pkg::sat36(36'(s2_q.ep) - 36'(s2_q.em));
  end
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c, am, ia, ic, g, ali, alc;
    logic signed [31:0] lap, ca, da, cc, dc;
    logic               clip;
  } s3_t;
  s3_t s3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q.kind <= s2_q.kind;
      s3_q.c    <= s2_q.c;
      s3_q.am   <= s2_q.am;
      s3_q.ia   <= s2_q.ia;
      s3_q.ic   <= s2_q.ic;
      s3_q.g    <= s2_q.g;
      s3_q.ali  <= s2_q.ali;
      s3_q.alc  <= s2_q.alc;
      s3_q.lap  <= d3[0][31:0];
      s3_q.ca   <= d3[1][31:0];
      s3_q.da   <= d3[2][31:0];
      s3_q.cc   <= d3[3][31:0];
      s3_q.dc   <= d3[4][31:0];
      s3_q.clip <= s2_q.clip | d3[0][32] | d3[1][32] | d3[2][32] | d3[3][32] | d3[4][32];
    end
  end

  // ---------------- Stage 4: scaled terms
  logic signed [31:0] t4 [5];
  logic [4:0]         c4;
  logic signed [32:0] inv_re;
  assign inv_re = {2'b00, cfg_i.inv_reynolds};
  dcmu_fmul #(.FracBits(FracBits)) u_m4a (
    .a_i(inv_re), .b_i(x33(s3_q.lap)), .p_o(t4[0]), .clip_o(c4[0])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m4b (
    .a_i(x33(s3_q.ia)), .b_i(x33(s3_q.ca)), .p_o(t4[1]), .clip_o(c4[1])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m4c (
    .a_i(x33(s3_q.ali)), .b_i(x33(s3_q.da)), .p_o(t4[2]), .clip_o(c4[2])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m4d (
    .a_i(x33(s3_q.ic)), .b_i(x33(s3_q.cc)), .p_o(t4[3]), .clip_o(c4[3])
  );
  dcmu_fmul #(.FracBits(FracBits)) u_m4e (
    .a_i(x33(s3_q.alc)), .b_i(x33(s3_q.dc)), .p_o(t4[4]), .clip_o(c4[4])
  );
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c, am, g, df, ca, da, cc, dc;
    logic               clip;
  } s4_t;
  s4_t s4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q.kind <= s3_q.kind;
      s4_q.c    <= s3_q.c;
      s4_q.am   <= s3_q.am;
      s4_q.g    <= s3_q.g;
      s4_q.df   <= t4[0];
      s4_q.ca   <= t4[1];
      s4_q.da   <= t4[2];
      s4_q.cc   <= t4[3];
      s4_q.dc   <= t4[4];
      s4_q.clip <= s3_q.clip | (|c4);
    end
  end

  // ---------------- Stage 5: right-hand side sum
  logic [32:0] rhs_w;
  assign rhs_w = dcmu_pkg::sat36(36'(s4_q.df) - 36'(s4_q.ca) - 36'(s4_q.da)
                                 - 36'(s4_q.cc) - 36'(s4_q.dc) + 36'(s4_q.g));
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c, am, rhs;
    logic               clip;
  } s5_t;
  s5_t s5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q.kind <= s4_q.kind;
      s5_q.c    <= s4_q.c;
      s5_q.am   <= s4_q.am;
      s5_q.rhs  <= rhs_w[31:0];
      s5_q.clip <= s4_q.clip | rhs_w[32];
    end
  end

  // ---------------- Stage 6: dt * rhs
  logic signed [31:0] dt_w;
  logic               cdt_w;
  logic signed [32:0] dt_op;
  assign dt_op = {2'b00, cfg_i.time_step};
  dcmu_fmul #(.FracBits(FracBits)) u_m6 (
    .a_i(dt_op), .b_i(x33(s5_q.rhs)), .p_o(dt_w), .clip_o(cdt_w)
  );
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] c, am, dt;
    logic               clip;
  } s6_t;
  s6_t s6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_q.kind <= s5_q.kind;
      s6_q.c    <= s5_q.c;
      s6_q.am   <= s5_q.am;
      s6_q.dt   <= dt_w;
      s6_q.clip <= s5_q.clip | cdt_w;
    end
  end

  // ---------------- Stage 7: final sum and cell-kind select
  logic [32:0] fin_w;
  assign fin_w = dcmu_pkg::sat36(36'(s6_q.c) + 36'(s6_q.dt));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (dcmu_pkg::cell_kind_e'(s6_q.kind))
        dcmu_pkg::KindFluid: begin
          item_o.momentum     <= fin_w[31:0];
          item_o.write_target <= dcmu_pkg::TgtThis;
          item_o.saturated    <= s6_q.clip | fin_w[32];
        end
        dcmu_pkg::KindObstMinus: begin
          item_o.momentum     <= s6_q.am;
          item_o.write_target <= dcmu_pkg::TgtMinus;
          item_o.saturated    <= 1'b0;
        end
        dcmu_pkg::KindObstPlus: begin
          item_o.momentum     <= s6_q.c;
          item_o.write_target <= dcmu_pkg::TgtThis;
          item_o.saturated    <= 1'b0;
        end
        default: begin
          item_o.momentum     <= '0;
          item_o.write_target <= dcmu_pkg::TgtNone;
          item_o.saturated    <= 1'b0;
        end
      endcase
    end
  end
endmodule

/* sv/donor_cell_momentum_update.sv */
// Top level of the donor-cell momentum update: config registers, stall control.
// Depends on dcmu_pkg and dcmu_core.
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o  dcmu_pkg::in_item_t
// out      output     out_valid_o/out_stall_i dcmu_pkg::out_item_t
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while the output does not stall; items pass through the pipelined multiplier stages.
// Reset clears valid bits and loads the default register values.
// The whole pipe advances together; a stall at the output holds every stage,
// and the input stalls only while the last stage holds an untaken item.
module donor_cell_momentum_update #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcmu_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcmu_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  dcmu_pkg::cfg_t cfg_q;
  logic           en;

  // Advance when the output slot is empty or being taken.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step       <= 31'((64'd1 << FRAC_BITS) / 100);
      cfg_q.inv_reynolds    <= 31'((64'd1 << FRAC_BITS) / 100);
      cfg_q.inv_cell_width  <= 31'(64'd1 << FRAC_BITS);
      cfg_q.inv_cell_height <= 31'(64'd1 << FRAC_BITS);
      cfg_q.upwind_blend    <= 17'((64'd9 << FRAC_BITS) / 10);
      cfg_q.gravity_x       <= '0;
      cfg_q.gravity_y       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dcmu_pkg::RegTimeStep:    cfg_q.time_step       <= cfg_data_i[30:0];
        dcmu_pkg::RegInvRe:       cfg_q.inv_reynolds    <= cfg_data_i[30:0];
        dcmu_pkg::RegInvDx:       cfg_q.inv_cell_width  <= cfg_data_i[30:0];
        dcmu_pkg::RegInvDy:       cfg_q.inv_cell_height <= cfg_data_i[30:0];
        dcmu_pkg::RegUpwindBlend: cfg_q.upwind_blend    <= cfg_data_i[16:0];
        dcmu_pkg::RegGravityX:    cfg_q.gravity_x       <= cfg_data_i;
        dcmu_pkg::RegGravityY:    cfg_q.gravity_y       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dcmu_core #(.FracBits(FRAC_BITS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );
endmodule
